/* rtl/pps_pkg.sv */
// Shared constants and beat types for the pipelined prime sieve.
package pps_pkg;

  localparam int MaxPrimes = 64;
  localparam int ValueBits = 16;

  // Wide enough to hold the fill count itself (0..MaxPrimes).
  localparam int CntW  = $clog2(MaxPrimes + 1);
  localparam int StepN = (MaxPrimes > ValueBits) ? MaxPrimes : ValueBits;
  localparam int StepW = $clog2(StepN);

  typedef struct packed {
    logic [ValueBits-1:0] candidate;
    logic                 end_of_stream;
  } in_beat_t;

  typedef struct packed {
    logic [ValueBits-1:0] number_out;
    logic                 is_prime;
    logic                 unverified;
    logic                 last_out;
  } out_beat_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                 clear;    // zero the running remainder
    logic                 step;     // take one dividend bit
    logic                 din;      // dividend bit, MSB first
    logic [ValueBits-1:0] wr_data;  // prime to store
  } cell_cmd_t;

endpackage

/* rtl/pps_cell.sv */
// One sieve cell: holds a prime, forms candidate mod prime bit-serially, ripples the hit flag.
module pps_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pps_pkg::cell_cmd_t  cmd_i,
  input  logic                wr_en_i,
  input  logic                active_i,
  input  logic                carry_i,
  output logic                carry_o
);

  logic [pps_pkg::ValueBits-1:0] prime_q;
  logic [pps_pkg::ValueBits-1:0] rem_q, rem_d;
  logic [pps_pkg::ValueBits:0]   shifted;
  logic                          carry_q, carry_d;

  // Restoring division step: shift in one bit, subtract the prime if it fits.
  // The remainder stays below the prime, so the difference fits the value width.
  always_comb begin
    shifted = {rem_q, cmd_i.din};
    if (shifted >= {1'b0, prime_q}) begin
      rem_d = shifted[pps_pkg::ValueBits-1:0] - prime_q;
    end else begin
      rem_d = shifted[pps_pkg::ValueBits-1:0];
    end
  end

  assign carry_d = carry_i | (active_i & (rem_q == '0));
  assign carry_o = carry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      prime_q <= cmd_i.wr_data;
    end
    if (cmd_i.clear) begin
      rem_q <= '0;
    end else if (cmd_i.step) begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= 1'b0;
    end else begin
      carry_q <= carry_d;
    end
  end

endmodule

/* rtl/pipelined_prime_sieve.sv */
// Top level of the prime sieve: sequencer, cell chain and output register.
//
// Usage: candidates enter on the in_* valid/ready channel as in_beat_t, results
// leave on the out_* valid/ready channel as out_beat_t, one result per beat.
// A row of 64 cells holds the primes found so far. Each accepted candidate is
// divided bit-serially in all cells at once (one dividend bit per cycle), then
// the "some prime divides it" flag ripples down the row, one cell per cycle.
// A final state forms the result and, for a new prime, stores it in the next
// free cell. A new beat is taken only once the last result has been formed;
// the time per item is set by the bit-serial remainder and the cell-to-cell
// flag ripple.
// A beat with end_of_stream set empties the table after its result is formed.
// Reset empties the table and drops any pending result. A result held by a
// stalled receiver sits in the output register while the next candidate is
// already accepted and worked on; the finished item waits until that register
// frees up.
module pipelined_prime_sieve (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  pps_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output pps_pkg::out_beat_t out_data_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StDiv   = 2'd1;
  localparam logic [1:0] StSweep = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]                    state_q, state_d;
  logic [pps_pkg::StepW-1:0]     step_q, step_d;
  logic [pps_pkg::CntW-1:0]      count_q, count_d;
  logic [pps_pkg::ValueBits-1:0] cand_q, cand_sh_q;
  logic                          last_q;
  logic                          out_valid_q;
  pps_pkg::out_beat_t            out_data_q;

  logic                          accept;
  logic                          fin_go;
  logic                          divided;
  logic                          is_prime;
  logic                          full;
  logic                          store;
  pps_pkg::cell_cmd_t            cmd;
  logic [pps_pkg::MaxPrimes:0]   carry;
  logic [pps_pkg::MaxPrimes-1:0] wr_en, active;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign fin_go     = (state_q == StFin) & (~out_valid_q | out_ready_i);

  assign divided  = carry[pps_pkg::MaxPrimes];
  assign is_prime = (cand_q >= pps_pkg::ValueBits'(2)) & ~divided;
  assign full     = (count_q == pps_pkg::CntW'(pps_pkg::MaxPrimes));
  assign store    = fin_go & is_prime & ~full;

  assign cmd.clear   = accept;
  assign cmd.step    = (state_q == StDiv);
  assign cmd.din     = cand_sh_q[pps_pkg::ValueBits-1];
  assign cmd.wr_data = cand_q;

  assign carry[0] = 1'b0;

  for (genvar i = 0; i < pps_pkg::MaxPrimes; i++) begin : g_cell
    assign active[i] = (count_q > pps_pkg::CntW'(i));
    assign wr_en[i]  = store & (count_q == pps_pkg::CntW'(i));

    pps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmd_i    (cmd),
      .wr_en_i  (wr_en[i]),
      .active_i (active[i]),
      .carry_i  (carry[i]),
      .carry_o  (carry[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    count_d = count_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          state_d = StDiv;
          step_d  = '0;
        end
      end
      StDiv: begin
        if (step_q == pps_pkg::StepW'(pps_pkg::ValueBits - 1)) begin
          state_d = StSweep;
          step_d  = '0;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StSweep: begin
        if (step_q == pps_pkg::StepW'(pps_pkg::MaxPrimes - 1)) begin
          state_d = StFin;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      StFin: begin
        if (fin_go) begin
          state_d = StIdle;
          if (last_q) begin
            count_d = '0;
          end else if (store) begin
            count_d = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      step_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      count_q <= count_d;
      if (fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q    <= in_data_i.candidate;
      cand_sh_q <= in_data_i.candidate;
      last_q    <= in_data_i.end_of_stream;
    end else if (state_q == StDiv) begin
      // advance to the next dividend bit
      cand_sh_q <= {cand_sh_q[pps_pkg::ValueBits-2:0], 1'b0};
    end
    if (fin_go) begin
      out_data_q.number_out <= cand_q;
      out_data_q.is_prime   <= is_prime;
      out_data_q.unverified <= is_prime & full;
      out_data_q.last_out   <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/tb_pipelined_prime_sieve.sv */
// Self-checking testbench for the pipelined prime sieve: predictor, stimulus and checks.
module tb_pipelined_prime_sieve;
  import pps_pkg::*;

  localparam int          TotalBeats = 850;
  localparam int unsigned CycleLimit = 500_000;
  localparam int          DrainWait  = 100;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_beat_t out_data;

  pipelined_prime_sieve u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #2 clk_i = ~clk_i;

  // Mirror of the sieve table
  logic [ValueBits-1:0] known_primes [MaxPrimes];
  int unsigned          known_count = 0;

  out_beat_t   pending_results [$];
  int unsigned error_count = 0;
  int unsigned beats_sent = 0;
  int unsigned cycle_count = 0;
  bit          tx_eager = 1'b0;
  bit          rx_eager = 1'b0;
  int unsigned rx_hold_cycles = 0;

  function automatic out_beat_t sieve_predict(in_beat_t beat);
    out_beat_t res;
    logic      divided;
    int        k;
    divided        = 1'b0;
    res.number_out = beat.candidate;
    res.is_prime   = 1'b0;
    res.unverified = 1'b0;
    res.last_out   = beat.end_of_stream;
    if (beat.candidate >= 2) begin
      for (k = 0; k < known_count; k++) begin
        if (known_primes[k] != 0 && beat.candidate % known_primes[k] == 0) divided = 1'b1;
      end
      if (!divided) begin
        res.is_prime = 1'b1;
        if (known_count < MaxPrimes) begin
          known_primes[known_count] = beat.candidate;
          known_count++;
        end else begin
          res.unverified = 1'b1;
        end
      end
    end
    if (beat.end_of_stream) known_count = 0;
    return res;
  endfunction

  // Check the result beat first, then log the input beat, so one edge cannot pair them
  always @(posedge clk_i) begin
    out_beat_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: number_out %0d", out_data.number_out);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.number_out !== want.number_out) begin
          $error("number_out: expected %0d, got %0d", want.number_out, out_data.number_out);
          error_count++;
        end
        if (out_data.is_prime !== want.is_prime) begin
          $error("is_prime (%0d): expected %0b, got %0b", want.number_out, want.is_prime,
                 out_data.is_prime);
          error_count++;
        end
        if (out_data.unverified !== want.unverified) begin
          $error("unverified (%0d): expected %0b, got %0b", want.number_out, want.unverified,
                 out_data.unverified);
          error_count++;
        end
        if (out_data.last_out !== want.last_out) begin
          $error("last_out (%0d): expected %0b, got %0b", want.number_out, want.last_out,
                 out_data.last_out);
          error_count++;
        end
      end
    end
    if (rst_ni && in_valid && in_ready) pending_results.push_back(sieve_predict(in_data));
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tb_pipelined_prime_sieve: done, errors");
      $finish;
    end
  end

  // Receiver: random stall per beat, or a long hold when asked
  initial begin
    int unsigned gap;
    @(posedge clk_i iff rst_ni);
    forever begin
      if (rx_hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk_i);
        rx_hold_cycles = 0;
      end
      gap = rx_eager ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
    end
  end

  task automatic send_beat(input logic [ValueBits-1:0] cand, input logic eos);
    int unsigned gap;
    gap = tx_eager ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid                <= 1'b1;
    in_data.candidate       <= cand;
    in_data.end_of_stream   <= eos;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
  endtask

  // Below two, small primes, repeats, extremes and a clear in between
  task automatic test_directed();
    send_beat(16'd0, 1'b0);
    send_beat(16'd1, 1'b0);
    send_beat(16'd2, 1'b0);
    send_beat(16'd3, 1'b0);
    send_beat(16'd4, 1'b0);
    send_beat(16'd2, 1'b0);
    send_beat(16'd65535, 1'b0);
    send_beat(16'd65521, 1'b0);
    send_beat(16'd32768, 1'b0);
    send_beat(16'd65521, 1'b0);
    send_beat(16'd5, 1'b1);
    send_beat(16'd65535, 1'b0);
    send_beat(16'd65535, 1'b0);
    send_beat(16'd32767, 1'b0);
    send_beat(16'd1, 1'b1);
    send_beat(16'd0, 1'b1);
    send_beat(16'd2, 1'b1);
    send_beat(16'd2, 1'b0);
  endtask

  // Count up from two past the 64th prime, with no idling on either side
  task automatic test_full_table();
    int n;
    tx_eager = 1'b1;
    rx_eager = 1'b1;
    send_beat(16'd9, 1'b1);
    for (n = 2; n <= 340; n++) send_beat(n[ValueBits-1:0], n == 340);
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  // Hold the receiver off while beats keep coming, so the input stalls
  task automatic test_backpressure();
    int n;
    rx_hold_cycles = 400;
    tx_eager       = 1'b1;
    for (n = 0; n < 6; n++) send_beat(16'(1000 + $urandom_range(0, 60)), 1'b0);
    tx_eager = 1'b0;
    send_beat(16'($urandom), 1'b1);
  endtask

  // Mostly ascending streams closed by a last beat; some noise and cut-off streams
  task automatic test_random_streams();
    int unsigned start, stride, len, n;
    bit          cut;
    while (beats_sent < TotalBeats) begin
      tx_eager = ($urandom_range(0, 4) == 0);
      rx_eager = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) != 0) begin
        start  = ($urandom_range(0, 3) == 0) ? 2 : $urandom_range(2, 65000);
        stride = $urandom_range(1, 6);
        len    = $urandom_range(8, 90);
        if ((65535 - start) / stride + 1 < len) len = (65535 - start) / stride + 1;
        cut = ($urandom_range(0, 5) == 0);
        for (n = 0; n < len; n++) begin
          send_beat(16'(start + n * stride), (n == len - 1) && !cut);
        end
      end else begin
        len = $urandom_range(1, 10);
        for (n = 0; n < len; n++) begin
          if ($urandom_range(0, 7) == 0) send_beat(16'($urandom_range(0, 1)), 1'b0);
          else send_beat(16'($urandom), ($urandom_range(0, 7) == 0));
        end
      end
    end
    tx_eager = 1'b0;
    rx_eager = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_table();
    test_backpressure();
    test_random_streams();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_pipelined_prime_sieve: done, clean");
    end else begin
      $display("tb_pipelined_prime_sieve: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/pps_pkg.sv
rtl/pps_cell.sv
rtl/pipelined_prime_sieve.sv
tb/tb_pipelined_prime_sieve.sv
